@@ rtl/dllm_pkg.sv @@
// ----------------------------------------------------------------------------
// Doubly linked list manager package
// Operation codes, item types and sizing constants shared by the list
// manager, its link memory and its port checker.
// ----------------------------------------------------------------------------
package dllm_pkg;

  // Width of the node number carried by an item; it bounds the addressable
  // node space whatever the pool size.
  localparam int NODE_W      = 6;
  localparam int NODE_SPACE  = 1 << NODE_W;
  localparam int COUNT_W     = 7;
  localparam int NODES_DEFAULT = 64;

  typedef enum logic [1:0] {
    OP_INS_HEAD = 2'd0,
    OP_INS_TAIL = 2'd1,
    OP_REM_HEAD = 2'd2,
    OP_REM_NODE = 2'd3
  } op_t;

  typedef struct packed {
    op_t               operation;
    logic [NODE_W-1:0] node;
  } cmd_t;

  typedef struct packed {
    logic [NODE_W-1:0]  removed_node;
    logic               removed_valid;
    logic               misuse;
    logic [COUNT_W-1:0] node_count;
    logic               list_empty;
  } res_t;

endpackage

@@ rtl/dllm_link_ram.sv @@
// ----------------------------------------------------------------------------
// Link memory
// One write port and one registered read port; a read of the address being
// written in the same cycle returns the new data.
// ----------------------------------------------------------------------------
module dllm_link_ram #(
  parameter int DEPTH = dllm_pkg::NODES_DEFAULT,
  parameter int WIDTH = 7
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data <= wr_data;
      end else begin
        rd_data <= mem[rd_addr];
      end
    end
  end

endmodule

@@ rtl/doubly_linked_list_manager.sv @@
// ----------------------------------------------------------------------------
// Doubly linked list manager
// Keeps one doubly linked list over a pool of node numbers and performs one
// insert or removal per item, with a membership check on every node.
// ----------------------------------------------------------------------------
// The block accepts one item per clock cycle while the result is not
// stalled: the item is registered together with the link words it needs,
// then one short pass of logic updates the list and loads the result
// register. Each operation reads and writes at most one entry of each link
// memory, which is what sets that rate. The list starts empty at reset and
// needs no clearing pass, because a link entry is only ever used for a node
// whose membership bit is set, and those bits clear at once.
// Inserting a node that is already in the list, removing a named node that
// is not in it, or naming a node outside the pool leaves the list unchanged
// and raises misuse; removing the head of an empty list is simply a no-op.
module doubly_linked_list_manager #(
  parameter int NODES = dllm_pkg::NODES_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_stall,
  input  dllm_pkg::cmd_t cmd,
  output logic          res_valid,
  input  logic          res_stall,
  output dllm_pkg::res_t res
);

  // Only node numbers that an item can name are ever stored, so the pool
  // held in hardware is the smaller of the two.
  localparam int DEPTH = (NODES < dllm_pkg::NODE_SPACE) ? NODES : dllm_pkg::NODE_SPACE;
  localparam int AW    = $clog2(DEPTH);
  localparam int LW    = $clog2(DEPTH + 1);
  localparam int CW    = LW;
  // The null link is the first number past the stored pool.
  localparam logic [LW-1:0] LINK_NULL = LW'(DEPTH);

  // Execute stage: the accepted item and the link words read for it.
  logic                        s1_valid;
  dllm_pkg::op_t               s1_op;
  logic [dllm_pkg::NODE_W-1:0] s1_node;
  logic                        s1_ok;
  logic [LW-1:0]               rd_next;
  logic [LW-1:0]               rd_prev;

  // List state.
  logic [LW-1:0]    head;
  logic [LW-1:0]    tail;
  logic [CW-1:0]    count;
  logic [DEPTH-1:0] in_list;

  logic [LW-1:0]    head_next;
  logic [LW-1:0]    tail_next;
  logic [CW-1:0]    count_next;
  logic [DEPTH-1:0] in_list_next;

  // Link memory write and read ports.
  logic          nx_we;
  logic [AW-1:0] nx_wa;
  logic [LW-1:0] nx_wd;
  logic          pv_we;
  logic [AW-1:0] pv_wa;
  logic [LW-1:0] pv_wd;
  logic [AW-1:0] nx_ra;
  logic [AW-1:0] pv_ra;

  logic cmd_fire;
  logic s1_move;

  logic [AW-1:0] s_idx;
  logic [LW-1:0] s_link;
  logic          member;
  logic [LW-1:0] prev_n;
  logic [LW-1:0] next_n;
  logic [LW-1:0] head_eff;

  logic [AW-1:0] removed;
  logic          removed_ok;
  logic          misuse;

  // The execute stage empties whenever the result register is free or is
  // being taken; a new item may then enter in the same cycle.
  assign s1_move   = s1_valid && (!res_valid || !res_stall);
  assign cmd_stall = s1_valid && !s1_move;
  assign cmd_fire  = cmd_valid && !cmd_stall;

  // A head removal needs the successor of the head as it will stand once
  // the item now executing has finished, so the read address follows the
  // next head value. Every other operation reads the links of its own node.
  assign head_eff = s1_move ? head_next : head;
  assign pv_ra    = AW'(cmd.node);
  assign nx_ra    = (cmd.operation == dllm_pkg::OP_REM_HEAD) ? AW'(head_eff) : AW'(cmd.node);

  dllm_link_ram #(
    .DEPTH (DEPTH),
    .WIDTH (LW)
  ) u_next_ram (
    .clk     (clk),
    .wr_en   (nx_we && s1_move),
    .wr_addr (nx_wa),
    .wr_data (nx_wd),
    .rd_en   (cmd_fire),
    .rd_addr (nx_ra),
    .rd_data (rd_next)
  );

  dllm_link_ram #(
    .DEPTH (DEPTH),
    .WIDTH (LW)
  ) u_prev_ram (
    .clk     (clk),
    .wr_en   (pv_we && s1_move),
    .wr_addr (pv_wa),
    .wr_data (pv_wd),
    .rd_en   (cmd_fire),
    .rd_addr (pv_ra),
    .rd_data (rd_prev)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cmd_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_fire) begin
      s1_op   <= cmd.operation;
      s1_node <= cmd.node;
      s1_ok   <= (32'(cmd.node) < NODES);
    end
  end

  // The stored links hold only what the list needs: the successor of every
  // member but the tail and the predecessor of every member but the head.
  // The ends are recognised by comparing with the head and tail registers,
  // so a link stored at an end of the list is never used.
  assign s_idx  = AW'(s1_node);
  assign s_link = LW'(s1_node);
  assign member = s1_ok && in_list[s_idx];

  always_comb begin
    head_next    = head;
    tail_next    = tail;
    count_next   = count;
    in_list_next = in_list;
    nx_we        = 1'b0;
    nx_wa        = s_idx;
    nx_wd        = head;
    pv_we        = 1'b0;
    pv_wa        = s_idx;
    pv_wd        = tail;
    removed      = '0;
    removed_ok   = 1'b0;
    misuse       = 1'b0;
    prev_n       = (s_link == head) ? LINK_NULL : rd_prev;
    next_n       = (s_link == tail) ? LINK_NULL : rd_next;

    unique case (s1_op)
      dllm_pkg::OP_INS_HEAD: begin
        if (!s1_ok || member) begin
          misuse = 1'b1;
        end else begin
          nx_we = 1'b1;
          nx_wa = s_idx;
          nx_wd = head;
          if (head == LINK_NULL) begin
            tail_next = s_link;
          end else begin
            pv_we = 1'b1;
            pv_wa = AW'(head);
            pv_wd = s_link;
          end
          head_next             = s_link;
          in_list_next[s_idx]   = 1'b1;
          count_next            = count + CW'(1);
        end
      end
      dllm_pkg::OP_INS_TAIL: begin
        if (!s1_ok || member) begin
          misuse = 1'b1;
        end else begin
          pv_we = 1'b1;
          pv_wa = s_idx;
          pv_wd = tail;
          if (tail == LINK_NULL) begin
            head_next = s_link;
          end else begin
            nx_we = 1'b1;
            nx_wa = AW'(tail);
            nx_wd = s_link;
          end
          tail_next             = s_link;
          in_list_next[s_idx]   = 1'b1;
          count_next            = count + CW'(1);
        end
      end
      dllm_pkg::OP_REM_HEAD: begin
        if (head != LINK_NULL) begin
          removed    = AW'(head);
          removed_ok = 1'b1;
          if (head == tail) begin
            head_next = LINK_NULL;
            tail_next = LINK_NULL;
          end else begin
            head_next = rd_next;
          end
          in_list_next[AW'(head)] = 1'b0;
          count_next              = count - CW'(1);
        end
      end
      dllm_pkg::OP_REM_NODE: begin
        if (!member) begin
          misuse = 1'b1;
        end else begin
          removed    = s_idx;
          removed_ok = 1'b1;
          if (s_link == head) begin
            head_next = next_n;
          end
          if (s_link == tail) begin
            tail_next = prev_n;
          end
          if (prev_n != LINK_NULL) begin
            nx_we = 1'b1;
            nx_wa = AW'(prev_n);
            nx_wd = next_n;
          end
          if (next_n != LINK_NULL) begin
            pv_we = 1'b1;
            pv_wa = AW'(next_n);
            pv_wd = prev_n;
          end
          in_list_next[s_idx] = 1'b0;
          count_next          = count - CW'(1);
        end
      end
      default: begin
        misuse = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head    <= LINK_NULL;
      tail    <= LINK_NULL;
      count   <= '0;
      in_list <= '0;
    end else if (s1_move) begin
      head    <= head_next;
      tail    <= tail_next;
      count   <= count_next;
      in_list <= in_list_next;
    end
  end

  // Result register: holds the item until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_move) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      res.removed_node  <= dllm_pkg::NODE_W'(removed);
      res.removed_valid <= removed_ok;
      res.misuse        <= misuse;
      res.node_count    <= dllm_pkg::COUNT_W'(count_next);
      res.list_empty    <= (count_next == '0);
    end
  end

endmodule

@@ rtl/dllm_checker.sv @@
// ----------------------------------------------------------------------------
// Doubly linked list manager port checker
// Watches both item channels of the list manager and checks that the items
// it shows are self-consistent and held while stalled.
// ----------------------------------------------------------------------------
module dllm_checker (
  input logic           clk,
  input logic           rst,
  input logic           cmd_valid,
  input logic           cmd_stall,
  input dllm_pkg::cmd_t cmd,
  input logic           res_valid,
  input logic           res_stall,
  input dllm_pkg::res_t res
);

  // A stalled operation item stays offered and unchanged.
  a_cmd_hold: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_stall |=> cmd_valid && $stable(cmd))
    else $error("operation item changed while stalled");

  // A stalled result item stays on the port unchanged.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res))
    else $error("result item changed while stalled");

  // The empty flag agrees with the count it is reported alongside.
  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res.list_empty == (res.node_count == '0)))
    else $error("empty flag disagrees with node count");

  // An ignored operation never unlinks a node.
  a_misuse_excl: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(res.misuse && res.removed_valid))
    else $error("misuse reported together with a removal");

  // A removal that did not happen reports node zero.
  a_removed_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.removed_valid |-> (res.removed_node == '0))
    else $error("removed node set without a removal");

endmodule

bind doubly_linked_list_manager dllm_checker u_dllm_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd_valid),
  .cmd_stall (cmd_stall),
  .cmd       (cmd),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res       (res)
);
